FILE: rtl/core/upe_pkg.sv
// Shared types, constants and character helpers for the URI percent encoder.
package upe_pkg;

	localparam int unsigned CmdQueueDepth = 2;
	localparam int unsigned SegCount      = 3;

	localparam logic [7:0] CharPercent = 8'h25;
	localparam logic [7:0] CharZero    = 8'h30;
	localparam logic [7:0] CharUpperA  = 8'h41;

	// How one segment of a command turns into output bytes.
	typedef enum logic [1:0] {
		SEG_NONE = 2'd0,
		SEG_RAW  = 2'd1,
		SEG_ENC  = 2'd2
	} seg_kind_t;

	typedef struct packed {
		seg_kind_t  kind;
		logic [7:0] data;
	} seg_t;

	// Segments are packed toward index 0; a NONE segment is never followed by a live one.
	typedef struct packed {
		seg_t [SegCount-1:0] seg;
		logic                eos;
	} cmd_t;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic keeps_byte(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
			8'h3B, 8'h2C, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B,
			8'h24, 8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28,
			8'h29, 8'h23};
	endfunction

	function automatic logic [7:0] hex_upper(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = CharZero + {4'b0000, n};
		end else begin
			r = CharUpperA + {4'b0000, n} - 8'd10;
		end
		return r;
	endfunction

	// Segment for a byte handled with nothing held; NONE means the byte is a held '%'.
	function automatic seg_t plain_seg(input logic [7:0] c, input logic eos);
		seg_t s;
		s.data = c;
		if (c == CharPercent) begin
			s.kind = eos ? SEG_ENC : SEG_NONE;
		end else if (keeps_byte(c)) begin
			s.kind = SEG_RAW;
		end else begin
			s.kind = SEG_ENC;
		end
		return s;
	endfunction

endpackage

FILE: rtl/core/upe_front.sv
// Front end: accepts input bytes, tracks a pending escape and issues output commands.
module upe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          end_of_string,
	output logic          push,
	output upe_pkg::cmd_t push_cmd,
	input  logic          queue_full
);
	import upe_pkg::*;

	typedef enum logic [2:0] {
		HOLD_NONE  = 3'b001,
		HOLD_PCT   = 3'b010,
		HOLD_DIGIT = 3'b100
	} hold_state_t;

	hold_state_t hold_q, hold_d;
	logic [7:0]  held_digit_q, held_digit_d;
	logic        accept;
	logic        has_out;
	seg_t        plain;
	seg_t        pct_enc;

	always_comb begin
		in_ready      = !queue_full;
		accept        = in_valid && !queue_full;
		plain         = plain_seg(in_byte, end_of_string);
		pct_enc.kind  = SEG_ENC;
		pct_enc.data  = CharPercent;
		hold_d        = HOLD_NONE;
		held_digit_d  = held_digit_q;
		has_out       = 1'b1;
		push_cmd.eos  = end_of_string;
		for (int i = 0; i < SegCount; i++) begin
			push_cmd.seg[i].kind = SEG_NONE;
			push_cmd.seg[i].data = in_byte;
		end
		case (hold_q)
			HOLD_PCT: begin
				if (is_hex(in_byte) && !end_of_string) begin
					hold_d       = HOLD_DIGIT;
					held_digit_d = in_byte;
					has_out      = 1'b0;
				end else begin
					push_cmd.seg[0] = pct_enc;
					push_cmd.seg[1] = plain;
					if (plain.kind == SEG_NONE) begin
						hold_d = HOLD_PCT;
					end
				end
			end
			HOLD_DIGIT: begin
				push_cmd.seg[1].kind = SEG_RAW;
				push_cmd.seg[1].data = held_digit_q;
				if (is_hex(in_byte)) begin
					// complete escape: pass it through verbatim
					push_cmd.seg[0].kind = SEG_RAW;
					push_cmd.seg[0].data = CharPercent;
					push_cmd.seg[2].kind = SEG_RAW;
				end else begin
					push_cmd.seg[0] = pct_enc;
					push_cmd.seg[2] = plain;
					if (plain.kind == SEG_NONE) begin
						hold_d = HOLD_PCT;
					end
				end
			end
			default: begin
				push_cmd.seg[0] = plain;
				if (plain.kind == SEG_NONE) begin
					hold_d  = HOLD_PCT;
					has_out = 1'b0;
				end
			end
		endcase
		push = accept && has_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_NONE;
		end else if (accept) begin
			hold_q <= hold_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_digit_q <= held_digit_d;
		end
	end

endmodule

FILE: rtl/core/upe_cmd_fifo.sv
// Short command queue between the front end and the output sequencer.
module upe_cmd_fifo #(
	parameter int unsigned DEPTH = upe_pkg::CmdQueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upe_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output upe_pkg::cmd_t head_cmd
);
	import upe_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

FILE: rtl/core/upe_back.sv
// Output sequencer: expands queued commands into bytes, one per cycle unless out_ready stalls the output.
module upe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  upe_pkg::cmd_t head_cmd,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          string_last
);
	import upe_pkg::*;

	localparam logic [1:0] SubLast = 2'd2;
	localparam logic [1:0] SegLast = 2'(SegCount - 1);

	logic [1:0] seg_idx_q, sub_q;
	logic       out_valid_q, run_last_q, string_last_q;
	logic [7:0] out_byte_q;

	seg_t       cur, nxt;
	logic [7:0] byte_d;
	logic       adv, step, seg_end, cmd_end;

	always_comb begin
		case (seg_idx_q)
			2'd0: begin
				cur = head_cmd.seg[0];
				nxt = head_cmd.seg[1];
			end
			2'd1: begin
				cur = head_cmd.seg[1];
				nxt = head_cmd.seg[2];
			end
			default: begin
				cur = head_cmd.seg[2];
				nxt = head_cmd.seg[2];
			end
		endcase
		if (cur.kind == SEG_RAW) begin
			byte_d = cur.data;
		end else begin
			case (sub_q)
				2'd0:    byte_d = CharPercent;
				2'd1:    byte_d = hex_upper(cur.data[7:4]);
				default: byte_d = hex_upper(cur.data[3:0]);
			endcase
		end
		seg_end = (cur.kind == SEG_RAW) || (sub_q == SubLast);
		cmd_end = seg_end && ((seg_idx_q == SegLast) || (nxt.kind == SEG_NONE));
		adv     = !out_valid_q || out_ready;
		step    = head_valid && adv;
		pop     = step && cmd_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_idx_q   <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= head_valid;
			end
			if (step) begin
				if (cmd_end) begin
					seg_idx_q <= '0;
					sub_q     <= '0;
				end else if (seg_end) begin
					seg_idx_q <= seg_idx_q + 1'b1;
					sub_q     <= '0;
				end else begin
					sub_q <= sub_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_byte_q    <= byte_d;
			run_last_q    <= cmd_end;
			string_last_q <= cmd_end && head_cmd.eos;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign run_last    = run_last_q;
	assign string_last = string_last_q;

endmodule

FILE: rtl/core/uri_percent_encoder_unit.sv
// A request with output is queued, then its bytes leave through the output register.
// The output sequencer emits one byte per cycle while out_ready allows; a request yields 0 to 7
// output bytes (1 for a kept byte, 3 for an encoded byte, up to 7 when a broken escape is flushed).
// The command queue (QUEUE_DEPTH entries) lets input requests land while output is busy.
// Reset clears the held escape, the queue and the output register; nothing is held afterward.
// Top level of the streaming URI percent encoder.
module uri_percent_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = upe_pkg::CmdQueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_last
);
	import upe_pkg::*;

	// Front to queue: one command per request that produces output.
	logic push, queue_full;
	cmd_t push_cmd;

	// Queue to back: head command, dropped once its last byte moves into the output register.
	logic head_valid, pop;
	cmd_t head_cmd;

	// Classify each request and hold '%' plus at most one hex digit until decided.
	upe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_byte      (in_byte),
		.end_of_string(end_of_string),
		.push         (push),
		.push_cmd     (push_cmd),
		.queue_full   (queue_full)
	);

	upe_cmd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	// Advance through the head command's segments, one output byte per cycle unless out_ready stalls.
	upe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_last(string_last)
	);

endmodule
